/* rtl/lat_pkg.sv */
// Shared widths, operation codes, register indexes and types of the life automaton.
package lat_pkg;

   localparam int OP_W        = 2;
   localparam int COORD_W     = 6;
   localparam int STEP_W      = 8;
   localparam int MASK_W      = 9;
   localparam int CSR_INDEX_W = 1;
   localparam int CNT_W       = 4;

   localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ    = 2'd1;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIRTH   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURVIVE = 1'd1;

   localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
   localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

   typedef struct packed {
      logic [MASK_W-1:0] birth;
      logic [MASK_W-1:0] survive;
   } rule_cfg_type;

endpackage

/* rtl/lat_if.sv */
// Request and response channel interfaces of the life automaton.
interface lat_req_if;
   logic                        valid;
   logic                        ready;
   logic [lat_pkg::OP_W-1:0]    operation;
   logic [lat_pkg::COORD_W-1:0] cell_x;
   logic [lat_pkg::COORD_W-1:0] cell_y;
   logic                        cell_value;
   logic [lat_pkg::STEP_W-1:0]  step_count;

   modport source (output valid, operation, cell_x, cell_y, cell_value, step_count,
                   input ready);
   modport sink (input valid, operation, cell_x, cell_y, cell_value, step_count,
                 output ready);
endinterface

interface lat_rsp_if;
   logic valid;
   logic ready;
   logic read_value;
   logic op_done;

   modport source (output valid, read_value, op_done, input ready);
   modport sink (input valid, read_value, op_done, output ready);
endinterface

/* rtl/lat_cell.sv */
// One row cell of the board ring: holds a full row and loads from its neighbor.
module lat_cell #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [WIDTH-1:0] row_in,
   output logic [WIDTH-1:0] row_ff
);

   // Load the neighbor's row or a write; clear the row on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (en) begin
         row_ff <= row_in;
      end
   end

endmodule

/* rtl/lat_rule.sv */
// Life rule over one row: wrapped neighbor count per column and birth/survive lookup.
module lat_rule #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]     above_row,
   input  logic [WIDTH-1:0]     mid_row,
   input  logic [WIDTH-1:0]     below_row,
   input  lat_pkg::rule_cfg_type rule_cfg,
   output logic [WIDTH-1:0]     next_row
);

   // Count the eight neighbors of each column, wrapping at the row ends
   always_comb begin
      int l;
      int r;
      logic [lat_pkg::CNT_W-1:0] cnt;
      next_row = '0;
      for (int c = 0; c < WIDTH; c++) begin
         l = (c == 0) ? WIDTH - 1 : c - 1;
         r = (c == WIDTH - 1) ? 0 : c + 1;
         cnt = lat_pkg::CNT_W'(above_row[l]) + lat_pkg::CNT_W'(above_row[c])
             + lat_pkg::CNT_W'(above_row[r]) + lat_pkg::CNT_W'(mid_row[l])
             + lat_pkg::CNT_W'(mid_row[r]) + lat_pkg::CNT_W'(below_row[l])
             + lat_pkg::CNT_W'(below_row[c]) + lat_pkg::CNT_W'(below_row[r]);
         next_row[c] = mid_row[c] ? rule_cfg.survive[cnt] : rule_cfg.birth[cnt];
      end
   end

endmodule

/* rtl/life_automaton_torus_top.sv */
// Top level of the toroidal life automaton: row ring, rule unit and sequencer.
// Read and write: the ring rotates d = 0..HEIGHT-1 times until the addressed row reaches the
// head cell; off-board reads and writes, unused codes and zero steps go straight to the response.
// Advance: each generation rotates the ring once, one row per cycle through the single rule
// unit at the ring's tail.
// One request is worked at a time; the next is accepted while the response waits.
// Synchronous reset clears every row cell at once (no clearing pass) and loads the masks.
module life_automaton_torus_top #(
   parameter int WIDTH  = 64,
   parameter int HEIGHT = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   lat_req_if.sink                             req_ch,
   lat_rsp_if.source                           rsp_ch,
   input  logic                                csr_we,
   input  logic [lat_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lat_pkg::MASK_W-1:0]          csr_wdata
);

   localparam int XW = $clog2(WIDTH);
   localparam int RW = $clog2(HEIGHT);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEEK = 2'd1;
   localparam logic [1:0] ST_GEN  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [RW-1:0]                head_ff, head_in;
   logic [RW-1:0]                pass_ff, pass_in;
   logic [lat_pkg::STEP_W-1:0]   gens_ff, gens_in;
   logic [lat_pkg::OP_W-1:0]     op_ff, op_in;
   logic [XW-1:0]                col_ff, col_in;
   logic [RW-1:0]                row_sel_ff, row_sel_in;
   logic                         val_ff, val_in;
   logic                         rd_ff, rd_in;
   logic                         done_ff, done_in;
   logic [WIDTH-1:0]             stash0_ff, stash0_in;
   logic [WIDTH-1:0]             stash1_ff, stash1_in;
   logic [lat_pkg::MASK_W-1:0]   birth_ff, survive_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_read_ff, rsp_read_in;
   logic                         rsp_done_ff, rsp_done_in;

   logic [WIDTH-1:0]             cell_row [HEIGHT];
   logic [WIDTH-1:0]             cell_in  [HEIGHT];
   logic [HEIGHT-1:0]            cell_en;
   logic [WIDTH-1:0]             feed_row;
   logic [WIDTH-1:0]             rule_row;
   logic [WIDTH-1:0]             mid_row;
   logic [WIDTH-1:0]             below_row;
   logic [WIDTH-1:0]             wr_row;
   lat_pkg::rule_cfg_type        rule_cfg;
   logic                         req_fire;
   logic                         on_board;
   logic                         hit;
   logic                         wr_hit;
   logic                         shift;
   logic                         last_pass;
   logic                         rsp_free;
   logic [RW-1:0]                head_step;

   // Row ring: each cell takes the row of the cell behind it; the tail takes the feed
   for (genvar i = 0; i < HEIGHT; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_en[i] = shift | wr_hit;
         assign cell_in[i] = wr_hit ? wr_row : cell_row[i+1];
      end else if (i == HEIGHT - 1) begin : g_tail
         assign cell_en[i] = shift;
         assign cell_in[i] = feed_row;
      end else begin : g_mid
         assign cell_en[i] = shift;
         assign cell_in[i] = cell_row[i+1];
      end
      lat_cell #(.WIDTH(WIDTH)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (cell_en[i]),
         .row_in (cell_in[i]),
         .row_ff (cell_row[i])
      );
   end

   // Pick rule inputs; the last two rows of a pass use the stashed first rows
   always_comb begin
      mid_row   = cell_row[1];
      below_row = cell_row[2];
      if (pass_ff == RW'(HEIGHT - 1)) begin
         mid_row   = stash0_ff;
         below_row = stash1_ff;
      end else if (pass_ff == RW'(HEIGHT - 2)) begin
         below_row = stash0_ff;
      end
   end

   assign rule_cfg.birth   = birth_ff;
   assign rule_cfg.survive = survive_ff;

   lat_rule #(.WIDTH(WIDTH)) u_rule (
      .above_row (cell_row[0]),
      .mid_row   (mid_row),
      .below_row (below_row),
      .rule_cfg  (rule_cfg),
      .next_row  (rule_row)
   );

   // Head cell access and ring control
   always_comb begin
      wr_row         = cell_row[0];
      wr_row[col_ff] = val_ff;
   end

   assign req_fire  = req_ch.valid & req_ch.ready;
   assign on_board  = (int'(req_ch.cell_x) < WIDTH) && (int'(req_ch.cell_y) < HEIGHT);
   assign hit       = (state_ff == ST_SEEK) && (head_ff == row_sel_ff);
   assign wr_hit    = hit && (op_ff == lat_pkg::OP_WRITE);
   assign shift     = ((state_ff == ST_SEEK) && !hit) || (state_ff == ST_GEN);
   assign feed_row  = (state_ff == ST_GEN) ? rule_row : cell_row[0];
   assign last_pass = (pass_ff == RW'(HEIGHT - 1));
   assign head_step = (head_ff == RW'(HEIGHT - 1)) ? '0 : head_ff + 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      pass_in      = pass_ff;
      gens_in      = gens_ff;
      op_in        = op_ff;
      col_in       = col_ff;
      row_sel_in   = row_sel_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      done_in      = done_ff;
      stash0_in    = stash0_ff;
      stash1_in    = stash1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_read_in  = rsp_read_ff;
      rsp_done_in  = rsp_done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in      = req_ch.operation;
               col_in     = XW'(req_ch.cell_x);
               row_sel_in = RW'(req_ch.cell_y);
               val_in     = req_ch.cell_value;
               rd_in      = 1'b0;
               done_in    = 1'b1;
               pass_in    = '0;
               unique case (req_ch.operation) inside
                  lat_pkg::OP_WRITE, lat_pkg::OP_READ: begin
                     state_in = on_board ? ST_SEEK : ST_DONE;
                  end
                  lat_pkg::OP_ADVANCE: begin
                     gens_in  = req_ch.step_count;
                     state_in = (req_ch.step_count == '0) ? ST_DONE : ST_GEN;
                  end
                  default: begin
                     done_in  = 1'b0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEEK: begin
            if (hit) begin
               rd_in    = (op_ff == lat_pkg::OP_READ) & cell_row[0][col_ff];
               state_in = ST_DONE;
            end else begin
               head_in = head_step;
            end
         end
         ST_GEN: begin
            if (pass_ff == '0) begin
               stash0_in = cell_row[0];
               stash1_in = cell_row[1];
            end
            if (last_pass) begin
               pass_in = '0;
               head_in = head_step;
               gens_in = gens_ff - 1'b1;
               if (gens_ff == lat_pkg::STEP_W'(1)) begin
                  state_in = ST_DONE;
               end
            end else begin
               pass_in = pass_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_read_in  = rd_ff;
               rsp_done_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control and payload state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         pass_ff      <= '0;
         gens_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         pass_ff      <= pass_in;
         gens_ff      <= gens_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      col_ff      <= col_in;
      row_sel_ff  <= row_sel_in;
      val_ff      <= val_in;
      rd_ff       <= rd_in;
      done_ff     <= done_in;
      stash0_ff   <= stash0_in;
      stash1_ff   <= stash1_in;
      rsp_read_ff <= rsp_read_in;
      rsp_done_ff <= rsp_done_in;
   end

   // Rule mask registers
   always_ff @(posedge clock) begin
      if (reset) begin
         birth_ff   <= lat_pkg::BIRTH_RESET;
         survive_ff <= lat_pkg::SURVIVE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lat_pkg::CSR_BIRTH:   birth_ff   <= csr_wdata;
            lat_pkg::CSR_SURVIVE: survive_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_read_ff;
   assign rsp_ch.op_done    = rsp_done_ff;

   // A generation pass never runs with nothing left to do
   a_gen_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GEN |-> gens_ff != '0)
      else $error("advance running with zero generations left");

   // The row counter only moves inside a pass and ends each pass at zero
   a_pass_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_GEN |-> pass_ff == '0)
      else $error("row counter not at zero outside a generation");

   // A write lands in the head cell at the addressed column
   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      wr_hit |=> cell_row[0][col_ff] == $past(val_ff))
      else $error("cell write lost");

   // The head row index stays on the board
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= RW'(HEIGHT - 1))
      else $error("head row index off the board");

endmodule
